FILE: src/e2c_pkg.sv
// Shared types and constants for the epoch-seconds to calendar converter.
// Holds the reciprocal constants for every divide-by-constant in the datapath.
// No dependencies; imported by every module in src.
package e2c_pkg;

    // Configuration of the conversion
    localparam int BASE_YEAR     = 1970;
    localparam int SECONDS_WIDTH = 32;
    localparam int IN_W          = 32;

    // Result field widths
    localparam int SEC_W   = 6;
    localparam int MIN_W   = 6;
    localparam int HOUR_W  = 5;
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 12;

    // Pipeline depths of the sub-blocks
    localparam int TOD_STAGES  = 4;
    localparam int DATE_STAGES = 9;
    localparam int TOD_ALIGN   = DATE_STAGES - TOD_STAGES;

    // Every divide below is q = (x * M) >> K, with K = width(x) + clog2(d)
    // and M = ceil(2^K / d); exact for every x of that width.

    // Seconds to whole days: 86400 = 128 * 675
    localparam int SECS_PER_DAY = 86400;
    localparam int DAY_SHIFT    = 7;
    localparam int DAY_ODD      = 675;
    localparam int XD_W         = SECONDS_WIDTH - DAY_SHIFT;
    localparam int KD           = XD_W + $clog2(DAY_ODD);
    localparam int MD_W         = XD_W + 1;
    localparam int PD_W         = XD_W + MD_W;
    localparam int DAYS_W       = PD_W - KD;
    localparam longint unsigned MD = ((64'd1 << KD) + DAY_ODD - 1) / DAY_ODD;

    // Time of day
    localparam int TOD_W     = 17;
    localparam int SECS_PER_HOUR = 3600;
    localparam int SECS_PER_MIN  = 60;
    localparam int HR_SHIFT  = 4;
    localparam int HR_ODD    = 225;
    localparam int XH_W      = TOD_W - HR_SHIFT;
    localparam int KH        = XH_W + $clog2(HR_ODD);
    localparam int MH_W      = XH_W + 1;
    localparam int PH_W      = XH_W + MH_W;
    localparam longint unsigned MH = ((64'd1 << KH) + HR_ODD - 1) / HR_ODD;
    localparam int REM_W     = 12;
    localparam int MN_SHIFT  = 2;
    localparam int MN_ODD    = 15;
    localparam int XM_W      = REM_W - MN_SHIFT;
    localparam int KM        = XM_W + $clog2(MN_ODD);
    localparam int MM_W      = XM_W + 1;
    localparam int PM_W      = XM_W + MM_W;
    localparam longint unsigned MM = ((64'd1 << KM) + MN_ODD - 1) / MN_ODD;

    // Day count shifted so that day 0 is 1 March of year 0
    localparam int PRIOR_YEAR   = BASE_YEAR - 1;
    localparam int EPOCH_OFFSET = PRIOR_YEAR * 365 + PRIOR_YEAR / 4 - PRIOR_YEAR / 100
                                  + PRIOR_YEAR / 400 + 306;
    localparam int Z_W          = $clog2(EPOCH_OFFSET + (1 << DAYS_W));

    // 400-year eras
    localparam int DAYS_PER_ERA  = 146097;
    localparam int YEARS_PER_ERA = 400;
    localparam int KE            = Z_W + $clog2(DAYS_PER_ERA);
    localparam int ME_W          = Z_W + 1;
    localparam int PE_W          = Z_W + ME_W;
    localparam int ERA_W         = PE_W - KE;
    localparam longint unsigned ME = ((64'd1 << KE) + DAYS_PER_ERA - 1) / DAYS_PER_ERA;

    // Day of era to year of era
    localparam int DOE_W      = 18;
    localparam int DOE_LAST   = DAYS_PER_ERA - 1;
    localparam int DAYS_4Y    = 1460;
    localparam int DAYS_100Y  = 36524;
    localparam int K4         = DOE_W + $clog2(DAYS_4Y);
    localparam int M4_W       = DOE_W + 1;
    localparam int P4_W       = DOE_W + M4_W;
    localparam int Q4_W       = P4_W - K4;
    localparam longint unsigned M4 = ((64'd1 << K4) + DAYS_4Y - 1) / DAYS_4Y;
    localparam int K100       = DOE_W + $clog2(DAYS_100Y);
    localparam int M100_W     = DOE_W + 1;
    localparam int P100_W     = DOE_W + M100_W;
    localparam int Q100_W     = P100_W - K100;
    localparam longint unsigned M100 = ((64'd1 << K100) + DAYS_100Y - 1) / DAYS_100Y;
    localparam int DAYS_1Y    = 365;
    localparam int KY         = DOE_W + $clog2(DAYS_1Y);
    localparam int MY_W       = DOE_W + 1;
    localparam int PY_W       = DOE_W + MY_W;
    localparam longint unsigned MY = ((64'd1 << KY) + DAYS_1Y - 1) / DAYS_1Y;
    localparam int YOE_W      = 9;

    // Year of era to century count
    localparam int YEARS_100 = 100;
    localparam int KC        = YOE_W + $clog2(YEARS_100);
    localparam int MC_W      = YOE_W + 1;
    localparam int PC_W      = YOE_W + MC_W;
    localparam int CENT_W    = PC_W - KC;
    localparam longint unsigned MC = ((64'd1 << KC) + YEARS_100 - 1) / YEARS_100;

    // Day of year to March-based month: mp = (5*doy + 2) / 153
    localparam int DOY_W     = 9;
    localparam int XP_W      = DOY_W + 2;
    localparam int MP_DIV    = 153;
    localparam int KP        = XP_W + $clog2(MP_DIV);
    localparam int MPM_W     = XP_W + 1;
    localparam int PP_W      = XP_W + MPM_W;
    localparam int MP_W      = 4;
    localparam longint unsigned MP = ((64'd1 << KP) + MP_DIV - 1) / MP_DIV;
    localparam int JAN_MP    = 10;

    // Absolute March-based year
    localparam int Y_W = ERA_W + YOE_W;

    typedef struct packed {
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  min;
        logic [SEC_W-1:0]  sec;
    } tod_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_t;

    // First day of year of each month, year starting in March
    function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
        logic [DOY_W-1:0] start;
        case (mp)
            4'd0:    start = 9'd0;
            4'd1:    start = 9'd31;
            4'd2:    start = 9'd61;
            4'd3:    start = 9'd92;
            4'd4:    start = 9'd122;
            4'd5:    start = 9'd153;
            4'd6:    start = 9'd184;
            4'd7:    start = 9'd214;
            4'd8:    start = 9'd245;
            4'd9:    start = 9'd275;
            4'd10:   start = 9'd306;
            4'd11:   start = 9'd337;
            default: start = 9'd0;
        endcase
        return start;
    endfunction

endpackage

FILE: src/e2c_tod.sv
// Time-of-day split: seconds within the day into hour, minute, second.
// Four register stages, no valid tracking (the top level carries it).
// Depends on e2c_pkg.
module e2c_tod
    import e2c_pkg::*;
(
    input  logic             clk,
    input  logic [TOD_W-1:0] tod,
    output tod_t             hms
);

    logic [TOD_W-1:0] s3_tod_reg;
    logic [PH_W-1:0]  s3_phr_reg;
    logic [PH_W-1:0]  s3_phr_next;
    logic [HOUR_W-1:0] s4_hour_reg;
    logic [HOUR_W-1:0] s4_hour_next;
    logic [REM_W-1:0] s4_rem_reg;
    logic [REM_W-1:0] s4_rem_next;
    logic [HOUR_W-1:0] s5_hour_reg;
    logic [REM_W-1:0] s5_rem_reg;
    logic [PM_W-1:0]  s5_pmin_reg;
    logic [PM_W-1:0]  s5_pmin_next;
    logic [MIN_W-1:0] s6_min_next;
    tod_t             hms_reg;
    tod_t             hms_next;

    // Hour quotient by reciprocal of 225 on tod / 16
    assign s3_phr_next = PH_W'(tod >> HR_SHIFT) * PH_W'(MH);

    // Hour and seconds left in the hour
    assign s4_hour_next = HOUR_W'(s3_phr_reg >> KH);
    assign s4_rem_next  = REM_W'(s3_tod_reg - TOD_W'(TOD_W'(s4_hour_next) * TOD_W'(SECS_PER_HOUR)));

    // Minute quotient by reciprocal of 15 on rem / 4
    assign s5_pmin_next = PM_W'(s4_rem_reg >> MN_SHIFT) * PM_W'(MM);

    // Minute and second
    assign s6_min_next = MIN_W'(s5_pmin_reg >> KM);
    always_comb
    begin
        hms_next.hour = s5_hour_reg;
        hms_next.min  = s6_min_next;
        hms_next.sec  = SEC_W'(s5_rem_reg - REM_W'(REM_W'(s6_min_next) * REM_W'(SECS_PER_MIN)));
    end

    always_ff @(posedge clk)
    begin
        s3_tod_reg  <= tod;
        s3_phr_reg  <= s3_phr_next;
        s4_hour_reg <= s4_hour_next;
        s4_rem_reg  <= s4_rem_next;
        s5_hour_reg <= s4_hour_reg;
        s5_rem_reg  <= s4_rem_reg;
        s5_pmin_reg <= s5_pmin_next;
        hms_reg     <= hms_next;
    end

    assign hms = hms_reg;

endmodule

FILE: src/e2c_date.sv
// Day count to Gregorian date (year, month, day), nine register stages.
// Era / year-of-era / day-of-year decomposition with March-based years.
// Depends on e2c_pkg.
module e2c_date
    import e2c_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [DAYS_W-1:0] days,
    output logic              out_valid,
    output date_t             date
);

    logic [DATE_STAGES-1:0] valid_reg;

    // stage 3
    logic [Z_W-1:0]   s3_z_reg;
    logic [Z_W-1:0]   s3_z_next;
    logic [PE_W-1:0]  s3_pera_reg;
    logic [PE_W-1:0]  s3_pera_next;
    // stage 4
    logic [ERA_W-1:0] s4_era_reg;
    logic [ERA_W-1:0] s4_era_next;
    logic [DOE_W-1:0] s4_doe_reg;
    logic [DOE_W-1:0] s4_doe_next;
    // stage 5
    logic [ERA_W-1:0] s5_era_reg;
    logic [DOE_W-1:0] s5_doe_reg;
    logic [P4_W-1:0]  s5_p4_reg;
    logic [P4_W-1:0]  s5_p4_next;
    logic [P100_W-1:0] s5_p100_reg;
    logic [P100_W-1:0] s5_p100_next;
    // stage 6
    logic [ERA_W-1:0] s6_era_reg;
    logic [DOE_W-1:0] s6_doe_reg;
    logic [DOE_W-1:0] s6_t_reg;
    logic [DOE_W-1:0] s6_t_next;
    // stage 7
    logic [ERA_W-1:0] s7_era_reg;
    logic [DOE_W-1:0] s7_doe_reg;
    logic [PY_W-1:0]  s7_py_reg;
    logic [PY_W-1:0]  s7_py_next;
    // stage 8
    logic [ERA_W-1:0] s8_era_reg;
    logic [DOE_W-1:0] s8_doe_reg;
    logic [YOE_W-1:0] s8_yoe_reg;
    logic [YOE_W-1:0] s8_yoe_next;
    logic [PC_W-1:0]  s8_pc_reg;
    logic [PC_W-1:0]  s8_pc_next;
    // stage 9
    logic [DOY_W-1:0] s9_doy_reg;
    logic [DOY_W-1:0] s9_doy_next;
    logic [Y_W-1:0]   s9_y_reg;
    logic [Y_W-1:0]   s9_y_next;
    logic [CENT_W-1:0] s9_cent;
    // stage 10
    logic [DOY_W-1:0] s10_doy_reg;
    logic [Y_W-1:0]   s10_y_reg;
    logic [PP_W-1:0]  s10_pmp_reg;
    logic [PP_W-1:0]  s10_pmp_next;
    // stage 11
    logic [MP_W-1:0]  s11_mp;
    date_t            date_reg;
    date_t            date_next;

    // Shift to March-based day count, start era quotient
    assign s3_z_next    = Z_W'(days) + Z_W'(EPOCH_OFFSET);
    assign s3_pera_next = PE_W'(s3_z_next) * PE_W'(ME);

    // Era and day of era
    assign s4_era_next = ERA_W'(s3_pera_reg >> KE);
    assign s4_doe_next = DOE_W'(s3_z_reg - Z_W'(Z_W'(s4_era_next) * Z_W'(DAYS_PER_ERA)));

    // Leap-day corrections: doe / 1460 and doe / 36524
    assign s5_p4_next   = P4_W'(s4_doe_reg) * P4_W'(M4);
    assign s5_p100_next = P100_W'(s4_doe_reg) * P100_W'(M100);

    // Day of era with leap days taken out
    assign s6_t_next = s5_doe_reg - DOE_W'(Q4_W'(s5_p4_reg >> K4))
                       + DOE_W'(Q100_W'(s5_p100_reg >> K100))
                       - DOE_W'(s5_doe_reg == DOE_W'(DOE_LAST));

    // Year of era quotient
    assign s7_py_next = PY_W'(s6_t_reg) * PY_W'(MY);

    // Year of era and its century count
    assign s8_yoe_next = YOE_W'(s7_py_reg >> KY);
    assign s8_pc_next  = PC_W'(s8_yoe_next) * PC_W'(MC);

    // Day of year and absolute year
    assign s9_cent     = CENT_W'(s8_pc_reg >> KC);
    assign s9_doy_next = DOY_W'(s8_doe_reg - (DOE_W'(DOE_W'(s8_yoe_reg) * DOE_W'(DAYS_1Y))
                         + DOE_W'(s8_yoe_reg >> 2) - DOE_W'(s9_cent)));
    assign s9_y_next   = Y_W'(Y_W'(s8_era_reg) * Y_W'(YEARS_PER_ERA)) + Y_W'(s8_yoe_reg);

    // March-based month quotient
    assign s10_pmp_next = PP_W'(XP_W'(XP_W'(s9_doy_reg) * XP_W'(5)) + XP_W'(2)) * PP_W'(MP);

    // Final month, day, January/February roll into the next year
    assign s11_mp = MP_W'(s10_pmp_reg >> KP);
    always_comb
    begin
        date_next.day   = DAY_W'(s10_doy_reg - month_start(s11_mp) + DOY_W'(1));
        date_next.month = (s11_mp < MP_W'(JAN_MP)) ? MONTH_W'(s11_mp + MP_W'(3))
                                                    : MONTH_W'(s11_mp - MP_W'(9));
        date_next.year  = YEAR_W'(s10_y_reg) + YEAR_W'(s11_mp >= MP_W'(JAN_MP));
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[DATE_STAGES-2:0], in_valid};
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        s3_z_reg    <= s3_z_next;
        s3_pera_reg <= s3_pera_next;
        s4_era_reg  <= s4_era_next;
        s4_doe_reg  <= s4_doe_next;
        s5_era_reg  <= s4_era_reg;
        s5_doe_reg  <= s4_doe_reg;
        s5_p4_reg   <= s5_p4_next;
        s5_p100_reg <= s5_p100_next;
        s6_era_reg  <= s5_era_reg;
        s6_doe_reg  <= s5_doe_reg;
        s6_t_reg    <= s6_t_next;
        s7_era_reg  <= s6_era_reg;
        s7_doe_reg  <= s6_doe_reg;
        s7_py_reg   <= s7_py_next;
        s8_era_reg  <= s7_era_reg;
        s8_doe_reg  <= s7_doe_reg;
        s8_yoe_reg  <= s8_yoe_next;
        s8_pc_reg   <= s8_pc_next;
        s9_doy_reg  <= s9_doy_next;
        s9_y_reg    <= s9_y_next;
        s10_doy_reg <= s9_doy_reg;
        s10_y_reg   <= s9_y_reg;
        s10_pmp_reg <= s10_pmp_next;
        date_reg    <= date_next;
    end

    assign out_valid = valid_reg[DATE_STAGES-1];
    assign date      = date_reg;

endmodule

FILE: src/epoch_seconds_to_calendar_top.sv
// Epoch seconds to Gregorian civil date and time, fully pipelined.
// done is the valid bit carried through the day-split registers and the date
// pipeline; the depth is set by the chain of reciprocal multiplies in the date path.
// Throughput: one transaction every cycle; busy is always low.
// Reset (rst_n, async, active low) clears the valid pipeline; nothing else.
// Depends on e2c_pkg, e2c_tod, e2c_date.
module epoch_seconds_to_calendar_top
    import e2c_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [IN_W-1:0]    epoch_seconds,
    output logic               done,
    output logic [SEC_W-1:0]   second_of_minute,
    output logic [MIN_W-1:0]   minute_of_hour,
    output logic [HOUR_W-1:0]  hour_of_day,
    output logic [DAY_W-1:0]   day_of_month,
    output logic [MONTH_W-1:0] month_of_year,
    output logic [YEAR_W-1:0]  calendar_year
);

    logic                     s1_valid_reg;
    logic                     s2_valid_reg;
    logic [SECONDS_WIDTH-1:0] s1_secs_reg;
    logic [SECONDS_WIDTH-1:0] s1_secs_next;
    logic [PD_W-1:0]          s1_pday_reg;
    logic [PD_W-1:0]          s1_pday_next;
    logic [DAYS_W-1:0]        s2_days_reg;
    logic [DAYS_W-1:0]        s2_days_next;
    logic [TOD_W-1:0]         s2_tod_reg;
    logic [TOD_W-1:0]         s2_tod_next;
    tod_t                     hms;
    tod_t                     hms_pipe_reg [TOD_ALIGN];
    date_t                    date;
    logic                     date_valid;

    // Never stalls
    assign busy = 1'b0;

    // Day quotient by reciprocal of 675 on secs / 128
    assign s1_secs_next = SECONDS_WIDTH'(epoch_seconds);
    assign s1_pday_next = PD_W'(s1_secs_next >> DAY_SHIFT) * PD_W'(MD);

    // Whole days and seconds within the day
    assign s2_days_next = DAYS_W'(s1_pday_reg >> KD);
    assign s2_tod_next  = TOD_W'(s1_secs_reg - SECONDS_WIDTH'(SECONDS_WIDTH'(s2_days_next)
                          * SECONDS_WIDTH'(SECS_PER_DAY)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_secs_reg <= s1_secs_next;
        s1_pday_reg <= s1_pday_next;
        s2_days_reg <= s2_days_next;
        s2_tod_reg  <= s2_tod_next;
    end

    e2c_tod u_tod (
        .clk (clk),
        .tod (s2_tod_reg),
        .hms (hms)
    );

    e2c_date u_date (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid_reg),
        .days      (s2_days_reg),
        .out_valid (date_valid),
        .date      (date)
    );

    // Hold time of day until the date path catches up
    always_ff @(posedge clk)
    begin
        hms_pipe_reg[0] <= hms;
        for (int i = 1; i < TOD_ALIGN; i++)
        begin
            hms_pipe_reg[i] <= hms_pipe_reg[i-1];
        end
    end

    // Result transaction
    assign done             = date_valid;
    assign second_of_minute = hms_pipe_reg[TOD_ALIGN-1].sec;
    assign minute_of_hour   = hms_pipe_reg[TOD_ALIGN-1].min;
    assign hour_of_day      = hms_pipe_reg[TOD_ALIGN-1].hour;
    assign day_of_month     = date.day;
    assign month_of_year    = date.month;
    assign calendar_year    = date.year;

endmodule
